[rtl/stun_message_parser_macros.svh]
// Assertion macros shared by the STUN message parser modules.
// Each module that uses them must have aclk and aresetn in scope.
`ifndef STUN_MESSAGE_PARSER_MACROS_SVH
`define STUN_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/smp_pkg.sv]
// Package of the STUN message parser: result codes, attribute codes and
// the structs passed between the parse stage and the output stage. No dependencies.
`default_nettype none

package smp_pkg;

    localparam int SMP_IN_W   = 24;
    localparam int SMP_OUT_W  = 176;
    localparam int SMP_ADDR_W = 3;

    // Result kinds.
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_OTHER   = 2'd1;
    localparam logic [1:0] KIND_LOCAL   = 2'd2;
    localparam logic [1:0] KIND_REMOTE  = 2'd3;

    // Summary status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_OVERRUN  = 2'd3;

    // Attribute types.
    localparam logic [15:0] ATTR_USERNAME    = 16'h0006;
    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_USE_CAND    = 16'h0025;
    localparam logic [15:0] ATTR_CONTROLLED  = 16'h8029;
    localparam logic [15:0] ATTR_CONTROLLING = 16'h802A;

    localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
    localparam logic [7:0]  CHAR_COLON  = 8'h3A;

    // Configuration register index.
    localparam logic REG_DECODE_MAPPED = 1'b0;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] msg_type;
        logic [31:0] txn_id_high;
        logic [63:0] txn_id_low;
        logic        use_cand;
        logic        role_controlled;
        logic        role_controlling;
        logic [15:0] xor_port;
        logic [31:0] xor_addr;
        logic        mapped_valid;
    } smp_summary_t;

    typedef struct packed {
        logic         usr_valid;
        logic [1:0]   usr_kind;
        logic [7:0]   usr_byte;
        logic         sum_valid;
        smp_summary_t summary;
    } smp_result_t;

endpackage

`default_nettype wire

[rtl/smp_parse.sv]
// Per-datagram parse state and the per-byte state update of the STUN parser.
// Depends on smp_pkg and the parser assertion macros.
`default_nettype none
`include "stun_message_parser_macros.svh"

module smp_parse (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    input  wire logic [7:0]           item_byte,
    input  wire logic [15:0]          item_len,
    input  wire logic                 item_last,
    input  wire logic                 decode_mapped,
    output smp_pkg::smp_result_t      result
);
    import smp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ATTR_HDR,
        PH_VALUE,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t       phase_reg,    phase_next;
    logic [15:0]  pos_reg,      pos_next;
    logic [15:0]  htype_reg,    htype_next;
    logic [15:0]  hlen_reg,     hlen_next;
    logic [31:0]  txn_hi_reg,   txn_hi_next;
    logic [63:0]  txn_lo_reg,   txn_lo_next;
    logic [15:0]  atype_reg,    atype_next;
    logic [15:0]  alen_reg,     alen_next;
    logic [16:0]  aoff_reg,     aoff_next;
    logic [1:0]   tok_reg,      tok_next;
    logic         in_tok_reg,   in_tok_next;
    logic         nul_reg,      nul_next;
    logic [1:0]   err_reg,      err_next;
    logic [2:0]   role_reg,     role_next;
    logic [48:0]  mapped_reg,   mapped_next;
    logic         mact_reg,     mact_next;

    logic [16:0]  consumed;
    logic [16:0]  aoff_inc;
    logic [16:0]  remain;
    logic [1:0]   pad_len;
    logic         room4;
    logic         usr_v;
    logic [1:0]   usr_kind;
    logic [1:0]   st;
    smp_summary_t summ;

    always_comb begin
        consumed = {1'b0, pos_reg} + 17'd1;
        aoff_inc = aoff_reg + 17'd1;
        remain   = {1'b0, item_len} - consumed;
        pad_len  = 2'd0 - alen_reg[1:0];
        // At least four bytes remain after this one: another attribute header fits.
        room4    = {2'b00, item_len} >= ({1'b0, consumed} + 18'd4);

        phase_next  = phase_reg;
        pos_next    = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
        htype_next  = htype_reg;
        hlen_next   = hlen_reg;
        txn_hi_next = txn_hi_reg;
        txn_lo_next = txn_lo_reg;
        atype_next  = atype_reg;
        alen_next   = alen_reg;
        aoff_next   = aoff_reg;
        tok_next    = tok_reg;
        in_tok_next = in_tok_reg;
        nul_next    = nul_reg;
        err_next    = err_reg;
        role_next   = role_reg;
        mapped_next = mapped_reg;
        mact_next   = mact_reg;
        usr_v       = 1'b0;
        usr_kind    = KIND_OTHER;

        if (phase_reg == PH_HEADER) begin
            if (pos_reg < 16'd2) begin
                htype_next = {htype_reg[7:0], item_byte};
            end else if (pos_reg < 16'd4) begin
                hlen_next = {hlen_reg[7:0], item_byte};
            end else if (pos_reg >= 16'd8 && pos_reg < 16'd12) begin
                txn_hi_next = {txn_hi_reg[23:0], item_byte};
            end else if (pos_reg >= 16'd12 && pos_reg < 16'd20) begin
                txn_lo_next = {txn_lo_reg[55:0], item_byte};
            end
            if (pos_reg >= 16'd19) begin
                if (item_len < 16'd20) begin
                    err_next   = STATUS_SHORT;
                    phase_next = PH_DONE;
                end else if ({1'b0, item_len} != 17'd20 + {1'b0, hlen_next}) begin
                    err_next   = STATUS_MISMATCH;
                    phase_next = PH_DONE;
                end else begin
                    aoff_next  = '0;
                    phase_next = room4 ? PH_ATTR_HDR : PH_DONE;
                end
            end
        end else if (phase_reg != PH_DONE && pos_reg >= item_len) begin
            // Bytes beyond the stated datagram length are ignored.
            phase_next = PH_DONE;
        end else begin
            unique case (phase_reg)
                PH_ATTR_HDR: begin
                    if (aoff_reg < 17'd2) begin
                        atype_next = {atype_reg[7:0], item_byte};
                    end else begin
                        alen_next = {alen_reg[7:0], item_byte};
                    end
                    aoff_next = aoff_inc;
                    if (aoff_inc >= 17'd4) begin
                        aoff_next = '0;
                        if (remain < {1'b0, alen_next}) begin
                            err_next   = STATUS_OVERRUN;
                            phase_next = PH_DONE;
                        end else begin
                            mact_next = 1'b0;
                            unique case (atype_next)
                                ATTR_USERNAME: begin
                                    tok_next    = '0;
                                    in_tok_next = 1'b0;
                                    nul_next    = 1'b0;
                                end
                                ATTR_USE_CAND:    role_next = role_reg | 3'b001;
                                ATTR_CONTROLLED:  role_next = role_reg | 3'b010;
                                ATTR_CONTROLLING: role_next = role_reg | 3'b100;
                                ATTR_XOR_MAPPED: begin
                                    if (decode_mapped) begin
                                        mapped_next = {1'b1, 48'd0};
                                        mact_next   = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                            if (alen_next != 16'd0) begin
                                phase_next = PH_VALUE;
                            end else begin
                                phase_next = room4 ? PH_ATTR_HDR : PH_DONE;
                            end
                        end
                    end
                end
                PH_VALUE: begin
                    if (atype_reg == ATTR_USERNAME) begin
                        usr_v = 1'b1;
                        if (nul_reg || item_byte == 8'd0) begin
                            nul_next = 1'b1;
                            usr_kind = KIND_OTHER;
                        end else if (item_byte == CHAR_COLON) begin
                            // Repeated and leading colons do not open a new token.
                            if (in_tok_reg) begin
                                in_tok_next = 1'b0;
                                if (tok_reg < 2'd2) begin
                                    tok_next = tok_reg + 2'd1;
                                end
                            end
                            usr_kind = KIND_OTHER;
                        end else begin
                            in_tok_next = 1'b1;
                            if (tok_reg == 2'd0) begin
                                usr_kind = KIND_LOCAL;
                            end else if (tok_reg == 2'd1) begin
                                usr_kind = KIND_REMOTE;
                            end else begin
                                usr_kind = KIND_OTHER;
                            end
                        end
                    end
                    if (mact_reg && aoff_reg >= 17'd2 && aoff_reg < 17'd8) begin
                        case (aoff_reg[2:0])
                            3'd2:    mapped_next[47:40] = item_byte;
                            3'd3:    mapped_next[39:32] = item_byte;
                            3'd4:    mapped_next[31:24] = item_byte;
                            3'd5:    mapped_next[23:16] = item_byte;
                            3'd6:    mapped_next[15:8]  = item_byte;
                            default: mapped_next[7:0]   = item_byte;
                        endcase
                    end
                    aoff_next = aoff_inc;
                    if (aoff_inc >= {1'b0, alen_reg}) begin
                        aoff_next = '0;
                        if (pad_len != 2'd0) begin
                            phase_next = PH_PAD;
                        end else begin
                            phase_next = room4 ? PH_ATTR_HDR : PH_DONE;
                        end
                    end
                end
                PH_PAD: begin
                    aoff_next = aoff_inc;
                    if (aoff_inc >= {15'd0, pad_len}) begin
                        aoff_next  = '0;
                        phase_next = room4 ? PH_ATTR_HDR : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // Summary, built from the state as updated by this byte.
        st = err_next;
        if (item_len < 16'd20) begin
            st = STATUS_SHORT;
        end else if (st == STATUS_OK && consumed != {1'b0, item_len}) begin
            st = STATUS_MISMATCH;
        end
        summ = '0;
        summ.status = st;
        if (st != STATUS_SHORT) begin
            summ.msg_type    = htype_next;
            summ.txn_id_high = txn_hi_next;
            summ.txn_id_low  = txn_lo_next;
        end
        if (st == STATUS_OK || st == STATUS_OVERRUN) begin
            summ.use_cand         = role_next[0];
            summ.role_controlled  = role_next[1];
            summ.role_controlling = role_next[2];
            if (mapped_next[48]) begin
                summ.xor_port     = mapped_next[47:32] ^ STUN_COOKIE[31:16];
                summ.xor_addr     = mapped_next[31:0] ^ STUN_COOKIE;
                summ.mapped_valid = 1'b1;
            end
        end

        result.usr_valid = item_valid && usr_v;
        result.usr_kind  = usr_kind;
        result.usr_byte  = item_byte;
        result.sum_valid = item_valid && item_last;
        result.summary   = summ;

        // The final byte of a datagram leaves clean state for the next one.
        if (item_last) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            htype_next  = '0;
            hlen_next   = '0;
            txn_hi_next = '0;
            txn_lo_next = '0;
            atype_next  = '0;
            alen_next   = '0;
            aoff_next   = '0;
            tok_next    = '0;
            in_tok_next = 1'b0;
            nul_next    = 1'b0;
            err_next    = STATUS_OK;
            role_next   = '0;
            mapped_next = '0;
            mact_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            htype_reg  <= '0;
            hlen_reg   <= '0;
            txn_hi_reg <= '0;
            txn_lo_reg <= '0;
            atype_reg  <= '0;
            alen_reg   <= '0;
            aoff_reg   <= '0;
            tok_reg    <= '0;
            in_tok_reg <= 1'b0;
            nul_reg    <= 1'b0;
            err_reg    <= STATUS_OK;
            role_reg   <= '0;
            mapped_reg <= '0;
            mact_reg   <= 1'b0;
        end else if (item_valid) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            htype_reg  <= htype_next;
            hlen_reg   <= hlen_next;
            txn_hi_reg <= txn_hi_next;
            txn_lo_reg <= txn_lo_next;
            atype_reg  <= atype_next;
            alen_reg   <= alen_next;
            aoff_reg   <= aoff_next;
            tok_reg    <= tok_next;
            in_tok_reg <= in_tok_next;
            nul_reg    <= nul_next;
            err_reg    <= err_next;
            role_reg   <= role_next;
            mapped_reg <= mapped_next;
            mact_reg   <= mact_next;
        end
    end

    `SMP_ASSERT_NXT(a_clear_after_last, item_valid && item_last,
                    pos_reg == 16'd0 && phase_reg == PH_HEADER && err_reg == STATUS_OK,
                    "parse state not cleared after the last byte")
    `SMP_ASSERT_IMP(a_mapped_needs_valid, mact_reg, mapped_reg[48],
                    "mapped decode active without the valid mark")
    `SMP_ASSERT_IMP(a_header_no_error, phase_reg == PH_HEADER, err_reg == STATUS_OK,
                    "error recorded while still in the header")

endmodule

`default_nettype wire

[rtl/smp_out.sv]
// Result stage of the STUN parser: holds the username result and the summary
// of one byte and hands them out in order. Depends on smp_pkg and the macros.
`default_nettype none
`include "stun_message_parser_macros.svh"

module smp_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire smp_pkg::smp_result_t          result,
    output logic                               free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [smp_pkg::SMP_OUT_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser
);
    import smp_pkg::*;

    logic         usr_v_reg;
    logic [1:0]   usr_kind_reg;
    logic [7:0]   usr_byte_reg;
    logic         sum_v_reg;
    smp_summary_t sum_reg;
    smp_summary_t shown;
    logic [7:0]   shown_byte;
    logic         take;

    assign m_tvalid = usr_v_reg || sum_v_reg;
    assign take     = m_tvalid && m_tready;
    // Empty now, or the one remaining result leaves this cycle.
    assign free     = !m_tvalid || (m_tready && (usr_v_reg ^ sum_v_reg));

    always_comb begin
        if (usr_v_reg) begin
            shown      = '0;
            shown_byte = usr_byte_reg;
            m_tuser    = usr_kind_reg;
        end else begin
            shown      = sum_reg;
            shown_byte = 8'd0;
            m_tuser    = KIND_SUMMARY;
        end
        m_tdata = {2'b00, shown.mapped_valid, shown.xor_addr, shown.xor_port,
                   shown.role_controlling, shown.role_controlled, shown.use_cand,
                   shown.txn_id_low, shown.txn_id_high, shown.msg_type,
                   shown.status, shown_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usr_v_reg <= 1'b0;
            sum_v_reg <= 1'b0;
        end else if (load) begin
            usr_v_reg <= result.usr_valid;
            sum_v_reg <= result.sum_valid;
        end else if (take) begin
            if (usr_v_reg) begin
                usr_v_reg <= 1'b0;
            end else begin
                sum_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            usr_kind_reg <= result.usr_kind;
            usr_byte_reg <= result.usr_byte;
            sum_reg      <= result.summary;
        end
    end

    `SMP_ASSERT_IMP(a_load_when_free, load, free, "result stage loaded while occupied")
    `SMP_ASSERT_IMP(a_user_kind, usr_v_reg, usr_kind_reg != KIND_SUMMARY,
                    "username result carries the summary kind")
    `SMP_ASSERT_NXT(a_summary_kept, usr_v_reg && sum_v_reg && !load, sum_v_reg,
                    "summary lost behind a username result")

endmodule

`default_nettype wire

[rtl/stun_message_parser.sv]
// STUN message parser: an accepted input byte passes the input register, then the
// result register, before its first result appears on the m_ side.
// Throughput is one byte per cycle unless m_tready stalls; a byte that yields both
// a username result and the summary is handed out as two results, stalling the input.
// aresetn is synchronous and active low; it clears the parse state to the header
// phase, empties both stages and sets the mapped-address decode register to 1.
`default_nettype none

module stun_message_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: data_byte [7:0], datagram_len [23:8]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [smp_pkg::SMP_IN_W-1:0]     s_tdata,
    input  wire logic                             s_tlast,
    // m_tdata: user_byte [7:0], status [9:8], msg_type [25:10],
    // txn_id_high [57:26], txn_id_low [121:58], use_cand [122],
    // role_controlled [123], role_controlling [124], xor_port [140:125],
    // xor_addr [172:141], mapped_valid [173], zero [175:174]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [smp_pkg::SMP_OUT_W-1:0]         m_tdata,
    // m_tuser: out_kind [1:0]
    output logic [1:0]                            m_tuser,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [smp_pkg::SMP_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import smp_pkg::*;

    logic        in_v_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_len_reg;
    logic        in_last_reg;
    logic        decode_reg;
    logic        free;
    logic        advance;
    smp_result_t result;

    assign pready   = 1'b1;
    assign advance  = in_v_reg && free;
    assign s_tready = !in_v_reg || free;
    assign prdata   = (paddr[2] == REG_DECODE_MAPPED) ? {31'd0, decode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DECODE_MAPPED) begin
            decode_reg <= pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[23:8];
            in_last_reg <= s_tlast;
        end
    end

    smp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (advance),
        .item_byte     (in_byte_reg),
        .item_len      (in_len_reg),
        .item_last     (in_last_reg),
        .decode_mapped (decode_reg),
        .result        (result)
    );

    smp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
